[hdl/ad_pkg.sv]
// Package with shared types and constants of the AdaDelta update block.
`default_nettype none
package ad_pkg;
   localparam int unsigned NumParamsDefault = 1024;
   localparam int unsigned IdxW = 10;
   localparam logic [15:0] DecayReset = 16'd58982;
   localparam logic [31:0] EpsReset   = 32'd17;
   localparam logic [31:0] RateReset  = 32'd16777216;

   typedef enum logic [1:0] {
      CSR_DECAY = 2'd0,
      CSR_EPS   = 2'd1,
      CSR_RATE  = 2'd2
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_RDW, ST_G2, ST_EG, ST_EGW, ST_SQA, ST_SQB,
      ST_P, ST_NUM, ST_DIV, ST_SAT, ST_D2, ST_EDX, ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;
endpackage
`default_nettype wire

[hdl/adadelta_step.sv]
// Top level of the per-parameter AdaDelta update block.
// Usage: an item (req_param_index, req_grad) enters on the req_ valid/ready
// channel; one signed Q8.24 direction leaves on the rsp_ channel per item.
// Registers decay, epsilon and rate are to be written over the csr_ channel
// only while the block is idle; the user must ensure this, as the block
// leaves it unchecked. csr_ready is always high. Items are processed one at
// a time. A bit-serial multiplier (one bit per cycle, early exit on small
// operands) forms every product, and a bit-serial unit takes two square
// roots and one restoring division, one bit per cycle. An in-range item's
// time to its result depends on operand sizes; an out-of-range one skips
// the arithmetic. The result sits in an output register; the next item is
// accepted while a stalled result waits, and the block holds before writing
// a new result. After reset the first NumParams entries of the two tables
// are cleared, one entry per cycle, during which req_ready is low.
// An out-of-range index gives direction 0 and leaves the tables unchanged.
`default_nettype none
module adadelta_step #(
   parameter int unsigned NumParams = ad_pkg::NumParamsDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ad_pkg::IdxW-1:0]   req_param_index,
   input  wire logic signed [31:0]        req_grad,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [31:0]             rsp_direction,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [31:0]               csr_data
);
   import ad_pkg::*;
   localparam int unsigned AW = (NumParams > 1) ? $clog2(NumParams) : 1;

   state_type st_ff, st_in;
   logic [15:0] decay_ff;
   logic [31:0] eps_ff, rate_ff;
   logic [AW:0] clr_ff, clr_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic neg_ff, neg_in;
   logic [31:0] gmag_ff, gmag_in;
   logic [31:0] eg_ff, eg_in, edx_ff, edx_in;
   logic [63:0] t_ff, t_in;      // scratch product
   logic [63:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [31:0] mag_ff, mag_in;
   logic        sat_ff, sat_in;
   logic [1:0]  sub_ff, sub_in;  // sub-step within a state
   logic        rsp_v_ff, rsp_v_in;
   logic [31:0] rsp_d_ff, rsp_d_in;
   // bit-serial sqrt / divide unit
   logic [65:0] rem_ff, rem_in;
   logic [63:0] qv_ff, qv_in, src_ff, src_in;
   logic [6:0]  bc_ff, bc_in;

   mul_req_type mreq;
   logic mbusy;
   logic [127:0] mprod;
   ad_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .busy(mbusy), .prod(mprod));

   logic we_g, we_d;
   logic [AW-1:0] addr;
   logic [31:0] wd_g, wd_d, rd_g, rd_d;
   ad_ram #(.Width(32), .Depth(2**AW)) u_eg (.clock(clock), .we(we_g), .addr(addr),
      .wdata(wd_g), .rdata(rd_g));
   ad_ram #(.Width(32), .Depth(2**AW)) u_edx (.clock(clock), .we(we_d), .addr(addr),
      .wdata(wd_d), .rdata(rd_d));

   logic [127:0] sum_w;
   logic [32:0]  epsum;
   logic [65:0]  trial;
   logic [31:0]  avg;
   always_comb begin
      sum_w = mprod + {64'd0, t_ff};
      avg = (sum_w[127:48] != 80'd0) ? 32'hFFFFFFFF : sum_w[47:16];
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DecayReset; eps_ff <= EpsReset; rate_ff <= RateReset;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_DECAY: decay_ff <= csr_data[15:0];
            CSR_EPS:   eps_ff <= csr_data;
            CSR_RATE:  rate_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_direction = rsp_d_ff;

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; idx_in = idx_ff; neg_in = neg_ff;
      gmag_in = gmag_ff; eg_in = eg_ff; edx_in = edx_ff; t_in = t_ff;
      ra_in = ra_ff; rb_in = rb_ff; mag_in = mag_ff; sat_in = sat_ff;
      sub_in = sub_ff; rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      rem_in = rem_ff; qv_in = qv_ff; src_in = src_ff; bc_in = bc_ff;
      mreq = '0; we_g = 1'b0; we_d = 1'b0; addr = idx_ff; wd_g = eg_ff; wd_d = edx_ff;
      epsum = 33'd0; trial = 66'd0;
      if (rsp_v_ff && rsp_ready) rsp_v_in = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            addr = clr_ff[AW-1:0]; wd_g = '0; wd_d = '0; we_g = 1'b1; we_d = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(NumParams - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = req_grad[31];
               gmag_in = req_grad[31] ? 32'(-req_grad) : req_grad;
               idx_in = AW'(req_param_index);
               if (32'(req_param_index) >= 32'(NumParams)) begin
                  mag_in = '0; neg_in = 1'b0; sat_in = 1'b0; st_in = ST_OUT;
               end else st_in = ST_RD;
            end
         end
         ST_RD: st_in = ST_RDW;
         ST_RDW: begin
            eg_in = rd_g; edx_in = rd_d;
            mreq.start = 1'b1; mreq.a = {32'd0, gmag_ff}; mreq.b = {32'd0, gmag_ff};
            st_in = ST_G2; sub_in = 2'd0;
         end
         ST_G2: if (!mbusy && sub_ff == 2'd0) begin
            sub_in = 2'd1;
         end else if (!mbusy) begin
            // sq = prod>>24; next: (65536-d)*sq, then d*old
            mreq.start = 1'b1; mreq.a = 64'(mprod[87:24]);
            mreq.b = {47'd0, 17'h10000 - {1'b0, decay_ff}};
            sub_in = 2'd0; st_in = ST_EG;
         end
         ST_EG: if (!mbusy && sub_ff == 2'd0) begin
            t_in = mprod[63:0];
            mreq.start = 1'b1; mreq.a = {32'd0, eg_ff}; mreq.b = {48'd0, decay_ff};
            sub_in = 2'd1;
         end else if (!mbusy && sub_ff == 2'd1) begin
            sub_in = 2'd2;
         end else if (!mbusy) begin
            eg_in = avg; st_in = ST_EGW;
         end
         ST_EGW: begin
            we_g = 1'b1;
            epsum = {1'b0, edx_ff} + {1'b0, eps_ff};
            src_in = 64'({epsum, 24'd0});
            rem_in = '0; qv_in = '0; bc_in = 7'd32; st_in = ST_SQA;
         end
         ST_SQA, ST_SQB: begin
            if (bc_ff != 7'd0) begin
               trial = {rem_ff[63:0], src_ff[63:62]} - {qv_ff, 2'b01};
               if (!trial[65]) begin
                  rem_in = trial; qv_in = {qv_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[63:0], src_ff[63:62]}; qv_in = {qv_ff[62:0], 1'b0};
               end
               src_in = src_ff << 2; bc_in = bc_ff - 7'd1;
            end else if (st_ff == ST_SQA) begin
               ra_in = qv_ff;
               epsum = {1'b0, eg_ff} + {1'b0, eps_ff};
               src_in = 64'({epsum, 24'd0});
               rem_in = '0; qv_in = '0; bc_in = 7'd32; st_in = ST_SQB;
            end else begin
               rb_in = qv_ff;
               mreq.start = 1'b1; mreq.a = {32'd0, rate_ff}; mreq.b = {32'd0, gmag_ff};
               sub_in = 2'd0; st_in = ST_P;
            end
         end
         ST_P: if (!mbusy && sub_ff == 2'd0) begin
            sub_in = 2'd1;
         end else if (!mbusy) begin
            mreq.start = 1'b1; mreq.a = mprod[87:24]; mreq.b = ra_ff;
            sub_in = 2'd0; st_in = ST_NUM;
         end
         ST_NUM: if (!mbusy && sub_ff == 2'd0) begin
            sub_in = 2'd1;
         end else if (!mbusy) begin
            sat_in = (mprod[127:64] != 64'd0);
            src_in = mprod[63:0]; rem_in = '0; qv_in = '0; bc_in = 7'd64;
            if (rb_ff == 64'd0) sat_in = (mprod != 128'd0);
            st_in = (mprod[127:64] != 64'd0 || rb_ff == 64'd0) ? ST_SAT : ST_DIV;
            if (st_in == ST_SAT) qv_in = '0;
         end
         ST_DIV: begin
            if (bc_ff != 7'd0) begin
               trial = {rem_ff[64:0], src_ff[63]} - {2'b00, rb_ff};
               if (!trial[65]) begin
                  rem_in = trial; qv_in = {qv_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[64:0], src_ff[63]}; qv_in = {qv_ff[62:0], 1'b0};
               end
               src_in = src_ff << 1; bc_in = bc_ff - 7'd1;
            end else st_in = ST_SAT;
         end
         ST_SAT: begin
            if (sat_ff || qv_ff > 64'h7FFFFFFF)
               mag_in = neg_ff ? 32'h80000000 : 32'h7FFFFFFF;
            else mag_in = qv_ff[31:0];
            st_in = ST_D2; sub_in = 2'd2;
         end
         ST_D2: if (sub_ff == 2'd2) begin
            mreq.start = 1'b1; mreq.a = {32'd0, mag_ff}; mreq.b = {32'd0, mag_ff};
            sub_in = 2'd0;
         end else if (!mbusy && sub_ff == 2'd0) begin
            sub_in = 2'd1;
         end else if (!mbusy) begin
            mreq.start = 1'b1; mreq.a = 64'(mprod[87:24]);
            mreq.b = {47'd0, 17'h10000 - {1'b0, decay_ff}};
            sub_in = 2'd0; st_in = ST_EDX;
         end
         ST_EDX: if (!mbusy && sub_ff == 2'd0) begin
            t_in = mprod[63:0];
            mreq.start = 1'b1; mreq.a = {32'd0, edx_ff}; mreq.b = {48'd0, decay_ff};
            sub_in = 2'd1;
         end else if (!mbusy && sub_ff == 2'd1) begin
            sub_in = 2'd2;
         end else if (!mbusy) begin
            wd_d = avg; we_d = 1'b1; st_in = ST_OUT;
         end
         ST_OUT: if (!rsp_v_ff || rsp_ready) begin
            rsp_v_in = 1'b1;
            rsp_d_in = neg_ff ? 32'(-mag_ff) : mag_ff;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; clr_ff <= '0; rsp_v_ff <= 1'b0; sub_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; rsp_v_ff <= rsp_v_in; sub_ff <= sub_in;
      end
      idx_ff <= idx_in; neg_ff <= neg_in; gmag_ff <= gmag_in; eg_ff <= eg_in;
      edx_ff <= edx_in; t_ff <= t_in; ra_ff <= ra_in; rb_ff <= rb_in;
      mag_ff <= mag_in; sat_ff <= sat_in; rsp_d_ff <= rsp_d_in;
      rem_ff <= rem_in; qv_ff <= qv_in; src_ff <= src_in; bc_ff <= bc_in;
   end
endmodule
`default_nettype wire

[hdl/ad_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module ad_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

[hdl/ad_mul.sv]
// Bit-serial shift-and-add multiplier, 64 by 64 to 128 bits.
`default_nettype none
module ad_mul
   import ad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   output logic             busy,
   output logic [127:0]     prod
);
   logic [127:0] acc_ff, acc_in;
   logic [127:0] mc_ff, mc_in;
   logic [63:0]  mp_ff, mp_in;
   logic [6:0]   cnt_ff, cnt_in;
   always_comb begin
      acc_in = acc_ff; mc_in = mc_ff; mp_in = mp_ff; cnt_in = cnt_ff;
      if (req.start) begin
         acc_in = '0; mc_in = {64'd0, req.a}; mp_in = req.b; cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in = mc_ff << 1;
         mp_in = mp_ff >> 1;
         cnt_in = cnt_ff - 7'd1;
         if (mp_ff[63:1] == 63'd0) cnt_in = 7'd0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      acc_ff <= acc_in; mc_ff <= mc_in; mp_ff <= mp_in;
   end
   assign busy = (cnt_ff != 7'd0);
   assign prod = acc_ff;
endmodule
`default_nettype wire

[verif/adadelta_step_tb.sv]
// Testbench for adadelta_step: random and directed gradients checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module adadelta_step_tb;
   import ad_pkg::*;

   class adadelta_scoreboard;
      logic [31:0] eg_table [1024];
      logic [31:0] edx_table [1024];
      logic [15:0] decay;
      logic [31:0] eps;
      logic [31:0] lrate;
      logic signed [31:0] pending_dirs [$];
      int mismatches;

      function new();
         foreach (eg_table[i]) begin
            eg_table[i] = '0;
            edx_table[i] = '0;
         end
         decay = DecayReset;
         eps = EpsReset;
         lrate = RateReset;
         mismatches = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [31:0] data);
         case (idx)
            CSR_DECAY: decay = data[15:0];
            CSR_EPS: eps = data;
            CSR_RATE: lrate = data;
            default: ;
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [31:0] blend(logic [31:0] old, longint unsigned sq);
         logic [79:0] s;
         s = (80'(decay) * old + 80'(17'd65536 - decay) * sq) >> 16;
         return (s > 80'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
      endfunction

      function void note_item(logic [9:0] idx, logic signed [31:0] g);
         logic neg;
         logic [32:0] gmag;
         longint unsigned ra, rb, p;
         logic [127:0] num, mag;
         logic [31:0] m32;
         neg = g[31];
         gmag = neg ? 33'(-34'(g)) : 33'(g);
         if (idx >= 1024) begin
            pending_dirs.push_back(0);
            return;
         end
         eg_table[idx] = blend(eg_table[idx], (64'(gmag) * gmag) >> 24);
         ra = int_sqrt((64'(edx_table[idx]) + eps) << 24);
         rb = int_sqrt((64'(eg_table[idx]) + eps) << 24);
         p = (64'(lrate) * gmag) >> 24;
         num = 128'(p) * ra;
         if (rb == 0) mag = (num != 0) ? 128'hFFFFFFFF : 0;
         else mag = num / rb;
         if (mag > 128'h7FFFFFFF) m32 = neg ? 32'h80000000 : 32'h7FFFFFFF;
         else m32 = mag[31:0];
         edx_table[idx] = blend(edx_table[idx], (64'(m32) * m32) >> 24);
         pending_dirs.push_back(neg ? -m32 : m32);
      endfunction

      function void check_result(logic signed [31:0] got);
         logic signed [31:0] want;
         if (pending_dirs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result direction=%h", got);
            return;
         end
         want = pending_dirs.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("direction mismatch: expected %h, got %h", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [IdxW-1:0] req_param_index = '0;
   logic signed [31:0] req_grad = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_direction;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic calm = 1'b0;
   int unsigned cycle_count = 0;
   adadelta_scoreboard board = new();

   adadelta_step uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_param_index(req_param_index), .req_grad(req_grad),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_direction(rsp_direction),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4000000) begin
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && csr_valid && csr_ready) board.write_reg(csr_idx_type'(csr_index), csr_data);
      if (!reset && req_valid && req_ready) board.note_item(req_param_index, req_grad);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_direction);
      rsp_ready <= calm || ($urandom_range(99) >= 37);
   end

   task automatic send_grad(logic [9:0] idx, logic signed [31:0] g);
      int gap;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 37) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_param_index <= idx;
      req_grad <= g;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_dirs.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic set_all(logic [15:0] d, logic [31:0] e, logic [31:0] r);
      write_csr(CSR_DECAY, 32'(d));
      write_csr(CSR_EPS, e);
      write_csr(CSR_RATE, r);
   endtask

   function automatic logic signed [31:0] rand_grad();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $signed($urandom) >>> $urandom_range(31);
         2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed($urandom) >>> $urandom_range(4, 12);
      endcase
   endfunction

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) begin
         calm <= (i >= n / 3) && (i < n / 3 + 60);
         send_grad($urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(15)), rand_grad());
      end
      calm <= 1'b0;
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_grad(0, 0);
      send_grad(1023, 32'sh7FFFFFFF);
      send_grad(1023, 32'sh80000000);
      send_grad(1, -1);
      send_grad(1, 1);
      send_grad(2, 32'sh01000000);
      send_grad(2, 32'sh01000000);
      send_grad(2, -32'sh01000000);
      drain();
      set_all(16'd0, 32'd0, 32'hFFFFFFFF);
      send_grad(5, 32'sh10000000);
      send_grad(5, 1);
      send_grad(6, 1);
      send_grad(7, 32'sh80000000);
      send_grad(7, 32'sh7FFFFFFF);
      drain();
      set_all(16'hFFFF, 32'hFFFFFFFF, 32'd1);
      send_grad(8, 32'sh80000000);
      send_grad(8, 32'sh12345678);
      drain();
      write_csr(CSR_RATE, 32'd0);
      send_grad(9, 32'sh7FFFFFFF);
      send_grad(9, -5);
      drain();
      set_all(DecayReset, EpsReset, RateReset);
      random_run(400);
      set_all(16'd0, 32'd0, 32'hFFFFFFFF);
      random_run(300);
      set_all(16'hFFFF, 32'hFFFFFFFF, 32'd1);
      random_run(300);
      set_all(16'($urandom), $urandom_range(1000), $urandom_range(1, 32'h04000000));
      random_run(300);
      set_all(16'($urandom), $urandom, $urandom);
      random_run(300);
      set_all(DecayReset, EpsReset, RateReset);
      random_run(330);
      if (board.mismatches == 0 && board.pending_dirs.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire
